>>> rtl/assert_macros.svh
// Assertion macros for the RTL, used by vad_back. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clock, reset_n, expr) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (expr)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(label, clock, reset_n, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clock, reset_n, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clock, reset_n, expr)
`define ASSERT_IMPLIES(label, clock, reset_n, ante, cons)
`define ASSERT_NEXT(label, clock, reset_n, ante, cons)

`endif

`endif

>>> rtl/vad_pkg.sv
package vad_pkg;

    localparam int COORD_WIDTH      = 16;
    localparam int ANGLE_ITERATIONS = 16;

    localparam int TABLE_LEN = 24;
    localparam int IDX_W     = $clog2(TABLE_LEN);
    localparam int NUM_CELLS = (ANGLE_ITERATIONS < TABLE_LEN) ? ANGLE_ITERATIONS : TABLE_LEN;

    localparam int PROD_W     = 2 * COORD_WIDTH;
    localparam int DOT_W      = PROD_W + 1;
    localparam int DOWN_SHIFT = ((2 * COORD_WIDTH - 1) > 52) ? (2 * COORD_WIDTH - 53) : 0;
    localparam int UP_SHIFT   = ((2 * COORD_WIDTH - 1) < 52) ? (53 - 2 * COORD_WIDTH) : 0;

    // The rotated vector stays below 2^53 in magnitude, including the CORDIC gain.
    localparam int DATA_W   = 56;
    localparam int ACC_W    = 34;
    localparam int ACC_FRAC = 24;
    localparam int OUT_FRAC = 8;
    localparam int OUT_W    = 16;
    localparam int RND_SHIFT = ACC_FRAC - OUT_FRAC;

    localparam int ANGLE_MAX = 46080;

    localparam logic signed [ACC_W-1:0] ACC_RIGHT_ANGLE = ACC_W'(90) <<< ACC_FRAC;

    // atan(2^-i) in degrees, Q8.24
    localparam logic signed [31:0] STEP_ANGLE [TABLE_LEN] = '{
        32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
        32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
        32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
        32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
        32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
        32'sd917,       32'sd458,       32'sd229,       32'sd115
    };

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [ACC_W-1:0]  acc;
        logic                     zero;
    } cordic_t;

endpackage

>>> rtl/vector_angle_degrees.sv
// Unsigned angle between two 2D vectors given as signed Q8.8 coordinates, returned in
// degrees as unsigned Q8.8 from 0 to 180. A new vector pair can be taken every clock
// cycle while in_stall is low. Each pair passes the product register, the register after
// the half-plane fold, the 16 CORDIC cells and the output register that holds the
// rounded result. Stalls ripple back only through occupied stages, so empty slots in the
// pipeline are filled while the output waits. If either vector is (0, 0) the angle reads
// as 0 and zero_vector is set.
module vector_angle_degrees
    import vad_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] first_x,
    input  logic signed [COORD_WIDTH-1:0] first_y,
    input  logic signed [COORD_WIDTH-1:0] second_x,
    input  logic signed [COORD_WIDTH-1:0] second_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [OUT_W-1:0]              angle_deg,
    output logic                          zero_vector
);

    cordic_t stage_data  [NUM_CELLS+1];
    logic    stage_valid [NUM_CELLS+1];
    logic    stage_stall [NUM_CELLS+1];

    vad_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .first_x   (first_x),
        .first_y   (first_y),
        .second_x  (second_x),
        .second_y  (second_y),
        .out_valid (stage_valid[0]),
        .out_stall (stage_stall[0]),
        .out_data  (stage_data[0])
    );

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        vad_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .step_idx  (IDX_W'(i)),
            .in_valid  (stage_valid[i]),
            .in_stall  (stage_stall[i]),
            .in_data   (stage_data[i]),
            .out_valid (stage_valid[i+1]),
            .out_stall (stage_stall[i+1]),
            .out_data  (stage_data[i+1])
        );
    end

    vad_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (stage_valid[NUM_CELLS]),
        .in_stall    (stage_stall[NUM_CELLS]),
        .in_data     (stage_data[NUM_CELLS]),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .angle_deg   (angle_deg),
        .zero_vector (zero_vector)
    );

endmodule

>>> rtl/vad_front.sv
module vad_front
    import vad_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] first_x,
    input  logic signed [COORD_WIDTH-1:0] first_y,
    input  logic signed [COORD_WIDTH-1:0] second_x,
    input  logic signed [COORD_WIDTH-1:0] second_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output cordic_t                       out_data
);

    logic                     s1_valid_reg;
    logic                     s1_stall;
    logic signed [PROD_W-1:0] p_xx_reg, p_yy_reg, p_xy_reg, p_yx_reg;
    logic                     zero_reg;

    logic                     s2_valid_reg;
    logic                     s2_stall;
    cordic_t                  s2_data_reg;
    cordic_t                  s2_data_next;

    logic signed [DOT_W-1:0]  dot;
    logic signed [DOT_W-1:0]  cross_sum;
    logic signed [DOT_W-1:0]  cross_abs;
    logic signed [DOT_W-1:0]  pre_x;
    logic signed [DOT_W-1:0]  pre_y;

    assign s2_stall = s2_valid_reg && out_stall;
    assign s1_stall = s1_valid_reg && s2_stall;
    assign in_stall = s1_stall;

    // Stage one: the four coordinate products.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!s1_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!s1_stall && in_valid)
        begin
            p_xx_reg <= PROD_W'(first_x) * PROD_W'(second_x);
            p_yy_reg <= PROD_W'(first_y) * PROD_W'(second_y);
            p_xy_reg <= PROD_W'(first_x) * PROD_W'(second_y);
            p_yx_reg <= PROD_W'(first_y) * PROD_W'(second_x);
            zero_reg <= ((first_x == '0) && (first_y == '0)) ||
                        ((second_x == '0) && (second_y == '0));
        end
    end

    // Stage two: dot and cross, then fold obtuse angles into the right half-plane.
    always_comb
    begin
        dot       = DOT_W'(p_xx_reg >>> DOWN_SHIFT) + DOT_W'(p_yy_reg >>> DOWN_SHIFT);
        cross_sum = DOT_W'(p_xy_reg >>> DOWN_SHIFT) - DOT_W'(p_yx_reg >>> DOWN_SHIFT);
        cross_abs = cross_sum[DOT_W-1] ? -cross_sum : cross_sum;
        s2_data_next.zero = zero_reg;
        if (dot[DOT_W-1])
        begin
            pre_x = cross_abs;
            pre_y = -dot;
            s2_data_next.acc = ACC_RIGHT_ANGLE;
        end
        else
        begin
            pre_x = dot;
            pre_y = cross_abs;
            s2_data_next.acc = '0;
        end
        s2_data_next.x = DATA_W'(pre_x) <<< UP_SHIFT;
        s2_data_next.y = DATA_W'(pre_y) <<< UP_SHIFT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (!s2_stall)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!s2_stall && s1_valid_reg)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

endmodule

>>> rtl/vad_cell.sv
module vad_cell
    import vad_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] step_idx,
    input  logic             in_valid,
    output logic             in_stall,
    input  cordic_t          in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output cordic_t          out_data
);

    logic                     valid_reg;
    cordic_t                  data_reg;
    cordic_t                  data_next;
    logic signed [DATA_W-1:0] dx;
    logic signed [DATA_W-1:0] dy;
    logic signed [ACC_W-1:0]  step;

    assign in_stall = valid_reg && out_stall;

    // One micro-rotation, driving y towards zero.
    always_comb
    begin
        dx   = in_data.y >>> step_idx;
        dy   = in_data.x >>> step_idx;
        step = ACC_W'(STEP_ANGLE[step_idx]);
        data_next.zero = in_data.zero;
        if (!in_data.y[DATA_W-1])
        begin
            data_next.x   = in_data.x + dx;
            data_next.y   = in_data.y - dy;
            data_next.acc = in_data.acc + step;
        end
        else
        begin
            data_next.x   = in_data.x - dx;
            data_next.y   = in_data.y + dy;
            data_next.acc = in_data.acc - step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/vad_back.sv
`include "assert_macros.svh"

module vad_back
    import vad_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  cordic_t          in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [OUT_W-1:0] angle_deg,
    output logic             zero_vector
);

    logic                    valid_reg;
    logic [OUT_W-1:0]        angle_reg;
    logic [OUT_W-1:0]        angle_next;
    logic                    zero_reg;
    logic signed [ACC_W:0]   rounded;
    logic signed [ACC_W:0]   deg;

    assign in_stall = valid_reg && out_stall;

    // Round half up to Q8.8, then clamp to the 0 to 180 degree range; a zero vector gives 0.
    always_comb
    begin
        rounded = (ACC_W + 1)'(in_data.acc) + ((ACC_W + 1)'(1) <<< (RND_SHIFT - 1));
        deg     = rounded >>> RND_SHIFT;
        priority if (in_data.zero || deg[ACC_W])
        begin
            angle_next = '0;
        end
        else if (deg > (ACC_W + 1)'(ANGLE_MAX))
        begin
            angle_next = OUT_W'(ANGLE_MAX);
        end
        else
        begin
            angle_next = deg[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            angle_reg <= angle_next;
            zero_reg  <= in_data.zero;
        end
    end

    assign out_valid   = valid_reg;
    assign angle_deg   = angle_reg;
    assign zero_vector = zero_reg;

    `ASSERT_IMPLIES(a_angle_range, clk, rst_n, valid_reg, angle_reg <= OUT_W'(ANGLE_MAX))
    `ASSERT_IMPLIES(a_zero_angle, clk, rst_n, valid_reg && zero_reg, angle_reg == '0)
    `ASSERT_NEXT(a_hold_result, clk, rst_n, valid_reg && out_stall, valid_reg && $stable(angle_reg) && $stable(zero_reg))

endmodule

>>> sim/vector_angle_checker.sv
`timescale 1ns / 1ps

module vector_angle_checker
    import vad_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] first_x,
    input  logic signed [COORD_WIDTH-1:0] first_y,
    input  logic signed [COORD_WIDTH-1:0] second_x,
    input  logic signed [COORD_WIDTH-1:0] second_y,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [OUT_W-1:0]              angle_deg,
    input  logic                          zero_vector,
    output int                            mismatch_count,
    output int                            pending_count
);

    localparam int MICRO_STEPS = 24;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [OUT_W-1:0] angle;
        logic             zero;
    } angle_result_t;

    angle_result_t expected_angles[$];
    angle_result_t want;
    int            mismatches = 0;

    assign mismatch_count = mismatches;

    initial pending_count = 0;

    // atan(2^-i) in degrees, Q8.24.
    function automatic longint atan_step_q24(input int i);
        case (i)
            0:  return 754974720;
            1:  return 445687602;
            2:  return 235489088;
            3:  return 119537938;
            4:  return 60000934;
            5:  return 30029717;
            6:  return 15018523;
            7:  return 7509720;
            8:  return 3754917;
            9:  return 1877466;
            10: return 938734;
            11: return 469367;
            12: return 234684;
            13: return 117342;
            14: return 58671;
            15: return 29335;
            16: return 14668;
            17: return 7334;
            18: return 3667;
            19: return 1833;
            20: return 917;
            21: return 458;
            22: return 229;
            default: return 115;
        endcase
    endfunction

    function automatic angle_result_t predict_angle(
        input logic signed [COORD_WIDTH-1:0] ax,
        input logic signed [COORD_WIDTH-1:0] ay,
        input logic signed [COORD_WIDTH-1:0] bx,
        input logic signed [COORD_WIDTH-1:0] by
    );
        longint        dot;
        longint        cross_prod;
        longint        x;
        longint        y;
        longint        t;
        longint        dx;
        longint        dy;
        longint        acc;
        longint        deg;
        int            i;
        angle_result_t r;

        r.angle = '0;
        r.zero  = 1'b0;
        if ((ax == 0 && ay == 0) || (bx == 0 && by == 0))
        begin
            r.zero = 1'b1;
            return r;
        end

        dot        = ((longint'(ax) * longint'(bx)) >>> DOWN_SHIFT)
                   + ((longint'(ay) * longint'(by)) >>> DOWN_SHIFT);
        cross_prod = ((longint'(ax) * longint'(by)) >>> DOWN_SHIFT)
                   - ((longint'(ay) * longint'(bx)) >>> DOWN_SHIFT);

        x   = dot;
        y   = (cross_prod < 0) ? -cross_prod : cross_prod;
        acc = 0;
        // An obtuse pair is turned back by a right angle so that the CORDIC
        // always starts in the right half-plane.
        if (x < 0)
        begin
            t   = x;
            x   = y;
            y   = -t;
            acc = longint'(90) <<< 24;
        end
        x = x <<< UP_SHIFT;
        y = y <<< UP_SHIFT;

        for (i = 0; i < ANGLE_ITERATIONS && i < MICRO_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x   = x + dx;
                y   = y - dy;
                acc = acc + atan_step_q24(i);
            end
            else
            begin
                x   = x - dx;
                y   = y + dy;
                acc = acc - atan_step_q24(i);
            end
        end

        deg = (acc + (longint'(1) <<< 15)) >>> 16;
        if (deg < 0)
            deg = 0;
        if (deg > ANGLE_MAX)
            deg = ANGLE_MAX;
        r.angle = OUT_W'(deg);
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_angles.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result with nothing expected: %s=%0d %s=%0b",
                                 $time, "angle_deg", angle_deg,
                                 "zero_vector", zero_vector);
                end
                else
                begin
                    want = expected_angles.pop_front();
                    if (angle_deg !== want.angle || zero_vector !== want.zero)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"%0t: mismatch: angle_deg exp %0d got %0d, ",
                                      "zero_vector exp %0b got %0b"},
                                     $time, want.angle, angle_deg,
                                     want.zero, zero_vector);
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_angles.push_back(predict_angle(first_x, first_y, second_x, second_y));
            pending_count <= expected_angles.size();
        end
    end

endmodule

>>> sim/vector_angle_degrees_tb.sv
`timescale 1ns / 1ps

module vector_angle_degrees_tb;
    import vad_pkg::*;

    localparam int IDLE_PERCENT = 17;
    localparam int RANDOM_PAIRS = 1500;
    localparam int QUIET_FIRST  = 700;
    localparam int QUIET_LAST   = 1000;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 40;

    logic                          clk;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    logic signed [COORD_WIDTH-1:0] first_x   = '0;
    logic signed [COORD_WIDTH-1:0] first_y   = '0;
    logic signed [COORD_WIDTH-1:0] second_x  = '0;
    logic signed [COORD_WIDTH-1:0] second_y  = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [OUT_W-1:0]              angle_deg;
    logic                          zero_vector;

    logic quiet       = 1'b0;
    int   idle_cycles = 0;
    int   mismatch_count;
    int   pending_count;

    vector_angle_degrees uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .first_x     (first_x),
        .first_y     (first_y),
        .second_x    (second_x),
        .second_y    (second_y),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .angle_deg   (angle_deg),
        .zero_vector (zero_vector)
    );

    vector_angle_checker angle_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .first_x        (first_x),
        .first_y        (first_y),
        .second_x       (second_x),
        .second_y       (second_y),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .angle_deg      (angle_deg),
        .zero_vector    (zero_vector),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
        out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);

    // Ends the run if neither channel completes a transfer for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("vector_angle_degrees_tb failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_pair(
        input logic signed [COORD_WIDTH-1:0] ax,
        input logic signed [COORD_WIDTH-1:0] ay,
        input logic signed [COORD_WIDTH-1:0] bx,
        input logic signed [COORD_WIDTH-1:0] by
    );
        int gap;

        gap = 0;
        if (!quiet)
            while ($urandom_range(0, 99) < IDLE_PERCENT)
                gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        first_x  <= ax;
        first_y  <= ay;
        second_x <= bx;
        second_y <= by;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    function automatic logic signed [COORD_WIDTH-1:0] extreme_coord();
        case ($urandom_range(0, 4))
            0:       return {1'b1, {(COORD_WIDTH-1){1'b0}}};
            1:       return {1'b0, {(COORD_WIDTH-1){1'b1}}};
            2:       return '0;
            3:       return 1;
            default: return -1;
        endcase
    endfunction

    initial
    begin
        logic signed [COORD_WIDTH-1:0] ax;
        logic signed [COORD_WIDTH-1:0] ay;
        logic signed [COORD_WIDTH-1:0] bx;
        logic signed [COORD_WIDTH-1:0] by;
        int                            pick;
        int                            scale;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero-length vectors on either side and on both.
        send_pair(0, 0, 0, 0);
        send_pair(0, 0, 5, 3);
        send_pair(-7, 2, 0, 0);
        // Parallel, opposite and square pairs, with the cross product of either sign.
        send_pair(256, 0, 256, 0);
        send_pair(256, 0, -256, 0);
        send_pair(256, 0, 0, 256);
        send_pair(256, 0, 0, -256);
        send_pair(256, 0, -256, 256);
        send_pair(0, 1, 0, -32768);
        send_pair(-1, -1, 1, 1);
        // Full-scale coordinates, where the dot product reaches its largest size.
        send_pair(-32768, -32768, -32768, -32768);
        send_pair(32767, 32767, -32768, -32768);
        send_pair(-32768, 32767, 32767, -32768);
        send_pair(32767, 0, 0, 32767);
        send_pair(-32768, 0, 0, -32768);
        // Tiny vectors and angles very close to 0 and to 180 degrees.
        send_pair(1, 0, -32768, 1);
        send_pair(1, 1, 1, -1);
        send_pair(1, 0, 1, 0);
        send_pair(32767, -1, 32767, 1);
        send_pair(12345, -6789, -23456, 321);

        for (int n = 0; n < RANDOM_PAIRS; n++)
        begin
            quiet = (n >= QUIET_FIRST && n < QUIET_LAST);
            pick  = $urandom_range(0, 99);
            if (pick < 60)
            begin
                ax = COORD_WIDTH'($urandom);
                ay = COORD_WIDTH'($urandom);
                bx = COORD_WIDTH'($urandom);
                by = COORD_WIDTH'($urandom);
            end
            else if (pick < 75)
            begin
                // Small coordinates turn up zero-length vectors often.
                ax = COORD_WIDTH'(int'($urandom_range(0, 6)) - 3);
                ay = COORD_WIDTH'(int'($urandom_range(0, 6)) - 3);
                bx = COORD_WIDTH'(int'($urandom_range(0, 6)) - 3);
                by = COORD_WIDTH'(int'($urandom_range(0, 6)) - 3);
            end
            else if (pick < 90)
            begin
                // Nearly parallel or nearly opposite pairs.
                ax    = COORD_WIDTH'($urandom);
                ay    = COORD_WIDTH'($urandom);
                scale = $urandom_range(0, 4);
                bx    = ax >>> scale;
                by    = ay >>> scale;
                if ($urandom_range(0, 1))
                begin
                    bx = -bx;
                    by = -by;
                end
                bx = bx + COORD_WIDTH'(int'($urandom_range(0, 2)) - 1);
                by = by + COORD_WIDTH'(int'($urandom_range(0, 2)) - 1);
            end
            else
            begin
                ax = extreme_coord();
                ay = extreme_coord();
                bx = extreme_coord();
                by = extreme_coord();
            end
            send_pair(ax, ay, bx, by);
        end
        quiet = 1'b0;
        in_valid <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("vector_angle_degrees_tb passed");
        else
            $display("vector_angle_degrees_tb failed");
        $finish;
    end

endmodule

>>> vector_angle_degrees.f
+incdir+rtl
rtl/vad_pkg.sv
rtl/vad_front.sv
rtl/vad_cell.sv
rtl/vad_back.sv
rtl/vector_angle_degrees.sv
sim/vector_angle_checker.sv
sim/vector_angle_degrees_tb.sv
